// ===== rtl/core/tat_pkg.sv =====
// Shared types and constants of the thermistor ADC to temperature block.
// Depends on nothing; every other file of the block but tat_div_pipe imports it.
package tat_pkg;

  localparam int SER_W      = 20;   // resistance registers
  localparam int BETA_W     = 14;
  localparam int NTEMP_W    = 15;
  localparam int TEMP_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Log values are e*2^30 + fraction, sized for ADC readings up to 16 bits.
  localparam int LOG_FRAC_W = 30;
  localparam int LOG_W      = 36;
  localparam int D_W        = 37;
  localparam int MAG_W      = 36;
  localparam int MAG_LO_W   = 18;
  localparam int PP_W       = MAG_LO_W + 28;
  localparam int X_SUM_W    = 64;
  localparam int T1_W       = 46;
  localparam int INV_W      = 48;
  localparam int TERM0_W    = 34;
  localparam int T0K_W      = 16;
  localparam int T0_NUM_W   = 47;

  localparam logic [27:0]        LN2_Q28      = 28'd186065279;
  localparam logic [INV_W-1:0]   HUNDRED_Q40  = 48'd100 << 40;
  localparam logic [TEMP_W-1:0]  KELVIN_CENTI = 17'd27315;
  localparam logic [TEMP_W-1:0]  TEMP_MAX     = 17'd50000;
  localparam logic [TEMP_W-1:0]  TEMP_MIN     = 17'h1D8F0;  // -10000

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERIES  = 2'd0,
    REG_NOMINAL = 2'd1,
    REG_BETA    = 2'd2,
    REG_NTEMP   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CFG_IDLE,
    CFG_LAUNCH,
    CFG_WAIT
  } cfg_state_t;

  // Values derived from the registers, handed to the arithmetic back end.
  typedef struct packed {
    logic [SER_W-1:0]   series;
    logic [BETA_W-1:0]  beta;
    logic [LOG_W-1:0]   lnom;
    logic [TERM0_W-1:0] term0;
  } tat_cfg_t;

endpackage

// ===== rtl/core/tat_lg2_pipe.sv =====
// Pipelined base-2 logarithm in Q30: one squaring step per stage.
// Depends on tat_pkg.
module tat_lg2_pipe #(
  parameter int X_W    = 36,
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_i,
  input  logic [X_W-1:0]            x_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic [tat_pkg::LOG_W-1:0] log_o,
  output logic [SIDE_W-1:0]         side_o
);
  import tat_pkg::*;

  localparam int E_W   = $clog2(X_W);
  localparam int FRAC  = LOG_FRAC_W;
  localparam int STEPS = LOG_FRAC_W;

  logic [E_W-1:0]    e_enc;
  logic              a_valid_r;
  logic [X_W-1:0]    a_x_r;
  logic [E_W-1:0]    a_e_r;
  logic [SIDE_W-1:0] a_side_r;
  logic [X_W+FRAC-1:0] a_shift;

  logic              v_r    [0:STEPS];
  logic [FRAC:0]     m_r    [0:STEPS];
  logic [FRAC-1:0]   f_r    [0:STEPS];
  logic [E_W-1:0]    e_r    [0:STEPS];
  logic [SIDE_W-1:0] side_r [0:STEPS];

  // Index of the top set bit.
  always_comb begin
    e_enc = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x_i[i]) e_enc = E_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_valid_r <= 1'b0;
    else        a_valid_r <= valid_i;
    a_x_r    <= x_i;
    a_e_r    <= e_enc;
    a_side_r <= side_i;
  end

  assign a_shift = {a_x_r, {FRAC{1'b0}}} >> a_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else        v_r[0] <= a_valid_r;
    m_r[0]    <= a_shift[FRAC:0];
    f_r[0]    <= '0;
    e_r[0]    <= a_e_r;
    side_r[0] <= a_side_r;
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [2*FRAC+1:0] sq;
    logic [FRAC+1:0]   t;
    assign sq = m_r[s] * m_r[s];
    assign t  = sq[2*FRAC+1:FRAC];
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s+1] <= 1'b0;
      else        v_r[s+1] <= v_r[s];
      m_r[s+1]    <= t[FRAC+1] ? t[FRAC+1:1] : t[FRAC:0];
      f_r[s+1]    <= {f_r[s][FRAC-2:0], t[FRAC+1]};
      e_r[s+1]    <= e_r[s];
      side_r[s+1] <= side_r[s];
    end
  end

  assign valid_o = v_r[STEPS];
  assign log_o   = {{(LOG_W-FRAC-E_W){1'b0}}, e_r[STEPS], f_r[STEPS]};
  assign side_o  = side_r[STEPS];

endmodule

// ===== rtl/core/tat_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tat_pkg only by convention; no package items are needed.
module tat_div_pipe #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 47,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quot_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_r    [0:NUM_W];
  logic [DEN_W:0]    rem_r  [0:NUM_W];
  logic [NUM_W-1:0]  num_r  [0:NUM_W];
  logic [NUM_W-1:0]  q_r    [0:NUM_W];
  logic [DEN_W-1:0]  den_r  [0:NUM_W];
  logic [SIDE_W-1:0] side_r [0:NUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else        v_r[0] <= valid_i;
    rem_r[0]  <= '0;
    num_r[0]  <= num_i;
    q_r[0]    <= '0;
    den_r[0]  <= den_i;
    side_r[0] <= side_i;
  end

  for (genvar s = 0; s < NUM_W; s++) begin : g_bit
    logic [DEN_W:0] trial;
    logic           fits;
    assign trial = {rem_r[s][DEN_W-1:0], num_r[s][NUM_W-1]};
    assign fits  = trial >= {1'b0, den_r[s]};
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s+1] <= 1'b0;
      else        v_r[s+1] <= v_r[s];
      rem_r[s+1]  <= fits ? trial - {1'b0, den_r[s]} : trial;
      num_r[s+1]  <= {num_r[s][NUM_W-2:0], 1'b0};
      q_r[s+1]    <= {q_r[s][NUM_W-2:0], fits};
      den_r[s+1]  <= den_r[s];
      side_r[s+1] <= side_r[s];
    end
  end

  assign valid_o = v_r[NUM_W];
  assign quot_o  = q_r[NUM_W];
  assign side_o  = side_r[NUM_W];

endmodule

// ===== rtl/core/tat_cfg.sv =====
// Configuration registers and the sequencer that derives log2(R0) and 1/T0.
// Depends on tat_pkg, tat_lg2_pipe and tat_div_pipe.
module tat_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tat_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           busy_o,
  output tat_pkg::tat_cfg_t              cfg_o
);
  import tat_pkg::*;

  cfg_state_t state_r, state_nxt;
  logic [SER_W-1:0]   series_r;
  logic [SER_W-1:0]   nominal_r;
  logic [BETA_W-1:0]  beta_r;
  logic [NTEMP_W-1:0] ntemp_r;
  logic [LOG_W-1:0]   lnom_r;
  logic [TERM0_W-1:0] term0_r;
  logic lg_done_r, lg_done_nxt;
  logic dv_done_r, dv_done_nxt;
  logic launch;
  logic wr;

  logic signed [T0K_W:0] t0k_s;
  logic [T0K_W-1:0]      t0k;
  logic [T0_NUM_W-1:0]   t0_num;
  logic                  lg_valid, dv_valid;
  logic [LOG_W-1:0]      lg_val;
  logic [T0_NUM_W-1:0]   dv_quot;

  assign cfg_ready = (state_r == CFG_IDLE);
  assign wr        = cfg_valid && cfg_ready;
  assign busy_o    = (state_r != CFG_IDLE);

  // Zero resistances and beta act as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r  <= SER_W'(10000);
      nominal_r <= SER_W'(10000);
      beta_r    <= BETA_W'(3950);
      ntemp_r   <= NTEMP_W'(2500);
    end else if (wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SERIES:  series_r  <= (cfg_data == '0) ? SER_W'(1) : cfg_data;
        REG_NOMINAL: nominal_r <= (cfg_data == '0) ? SER_W'(1) : cfg_data;
        REG_BETA:    beta_r    <= (cfg_data[BETA_W-1:0] == '0) ? BETA_W'(1)
                                                              : cfg_data[BETA_W-1:0];
        REG_NTEMP:   ntemp_r   <= cfg_data[NTEMP_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    lg_done_nxt = lg_done_r || lg_valid;
    dv_done_nxt = dv_done_r || dv_valid;
    launch      = 1'b0;
    unique case (state_r)
      CFG_IDLE: begin
        if (wr) state_nxt = CFG_LAUNCH;
      end
      CFG_LAUNCH: begin
        launch      = 1'b1;
        lg_done_nxt = 1'b0;
        dv_done_nxt = 1'b0;
        state_nxt   = CFG_WAIT;
      end
      CFG_WAIT: begin
        if (lg_done_nxt && dv_done_nxt) state_nxt = CFG_IDLE;
      end
      default: state_nxt = CFG_LAUNCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= CFG_LAUNCH;
      lg_done_r <= 1'b0;
      dv_done_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      lg_done_r <= lg_done_nxt;
      dv_done_r <= dv_done_nxt;
    end
  end

  assign t0k_s  = {{2{ntemp_r[NTEMP_W-1]}}, ntemp_r} + 17'sd27315;
  assign t0k    = t0k_s[T0K_W-1:0];
  assign t0_num = HUNDRED_Q40[T0_NUM_W-1:0] + {{(T0_NUM_W-T0K_W+1){1'b0}}, t0k[T0K_W-1:1]};

  tat_lg2_pipe #(.X_W(SER_W), .SIDE_W(1)) u_lg_nom (
    .clk(clk), .rst_n(rst_n), .valid_i(launch), .x_i(nominal_r), .side_i(1'b0),
    .valid_o(lg_valid), .log_o(lg_val), .side_o()
  );

  tat_div_pipe #(.NUM_W(T0_NUM_W), .DEN_W(T0K_W), .SIDE_W(1)) u_div_t0 (
    .clk(clk), .rst_n(rst_n), .valid_i(launch), .num_i(t0_num), .den_i(t0k),
    .side_i(1'b0), .valid_o(dv_valid), .quot_o(dv_quot), .side_o()
  );

  always_ff @(posedge clk) begin
    if (lg_valid) lnom_r  <= lg_val;
    if (dv_valid) term0_r <= dv_quot[TERM0_W-1:0];
  end

  assign cfg_o.series = series_r;
  assign cfg_o.beta   = beta_r;
  assign cfg_o.lnom   = lnom_r;
  assign cfg_o.term0  = term0_r;

endmodule

// ===== rtl/core/tat_front.sv =====
// Front end: takes readings, clamps them into range and queues them.
// Depends on tat_pkg.
module tat_front #(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept_i,
  input  logic [ADC_BITS-1:0] raw_i,
  output logic                full_o,
  output logic                valid_o,
  output logic [ADC_BITS-1:0] raw_o,
  output logic                clamped_o
);
  import tat_pkg::*;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam logic [ADC_BITS-1:0] FS = {ADC_BITS{1'b1}};

  logic [ADC_BITS:0]      mem [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]         count_r;
  logic [ADC_BITS-1:0]    raw_fix;
  logic                   clamp;
  logic                   pop;

  always_comb begin
    raw_fix = raw_i;
    clamp   = 1'b0;
    if (raw_i == '0) begin
      raw_fix = ADC_BITS'(1);
      clamp   = 1'b1;
    end else if (raw_i == FS) begin
      raw_fix = FS - ADC_BITS'(1);
      clamp   = 1'b1;
    end
  end

  // The back end never stalls, so the head leaves whenever there is one.
  assign pop       = (count_r != '0);
  assign valid_o   = pop;
  assign full_o    = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign raw_o     = mem[rd_ptr_r][ADC_BITS-1:0];
  assign clamped_o = mem[rd_ptr_r][ADC_BITS];

  always_ff @(posedge clk) begin
    if (accept_i) mem[wr_ptr_r] <= {clamp, raw_fix};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (accept_i) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)      rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_r + (PTR_W+1)'(accept_i) - (PTR_W+1)'(pop);
    end
  end

endmodule

// ===== rtl/core/tat_back.sv =====
// Back end: resistance ratio log, beta equation and final reciprocal.
// Depends on tat_pkg, tat_lg2_pipe and tat_div_pipe.
module tat_back #(
  parameter int ADC_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  input  logic [ADC_BITS-1:0]         raw_i,
  input  logic                        clamped_i,
  input  tat_pkg::tat_cfg_t           cfg_i,
  output logic                        strobe_o,
  output logic [tat_pkg::TEMP_W-1:0]  temp_o,
  output logic                        clamped_o,
  output logic                        sat_o
);
  import tat_pkg::*;

  localparam int PROD_W = SER_W + ADC_BITS;
  localparam logic [ADC_BITS-1:0] FS = {ADC_BITS{1'b1}};
  localparam logic [INV_W-1:0] Q_HI = 48'd77315;
  localparam logic [INV_W-1:0] Q_LO = 48'd17315;

  // Stage 1: series * raw and full scale minus raw.
  logic                v1_r, c1_r;
  logic [PROD_W-1:0]   prod_r;
  logic [ADC_BITS-1:0] fsr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= valid_i;
    c1_r   <= clamped_i;
    prod_r <= cfg_i.series * raw_i;
    fsr_r  <= FS - raw_i;
  end

  logic             lg_valid, lg_c;
  logic [LOG_W-1:0] l1, l2;

  tat_lg2_pipe #(.X_W(PROD_W), .SIDE_W(1)) u_lg_num (
    .clk(clk), .rst_n(rst_n), .valid_i(v1_r), .x_i(prod_r), .side_i(c1_r),
    .valid_o(lg_valid), .log_o(l1), .side_o(lg_c)
  );

  tat_lg2_pipe #(.X_W(ADC_BITS), .SIDE_W(1)) u_lg_den (
    .clk(clk), .rst_n(rst_n), .valid_i(v1_r), .x_i(fsr_r), .side_i(1'b0),
    .valid_o(), .log_o(l2), .side_o()
  );

  // Log difference, magnitude, split product by ln 2, rounding add.
  logic                  vd_r, cd_r, vm_r, cm_r, nm_r, vp_r, cp_r, np_r, vx_r, cx_r, nx_r;
  logic signed [D_W-1:0] d_r;
  logic [MAG_W-1:0]      mag_r;
  logic [PP_W-1:0]       pl_r, ph_r;
  logic [X_SUM_W-1:0]    xsum;
  logic [T1_W-1:0]       x_r;

  assign xsum = {ph_r, {MAG_LO_W{1'b0}}} + {{(X_SUM_W-PP_W){1'b0}}, pl_r}
              + {{(X_SUM_W-BETA_W-17){1'b0}}, cfg_i.beta, 17'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      vm_r <= 1'b0;
      vp_r <= 1'b0;
      vx_r <= 1'b0;
    end else begin
      vd_r <= lg_valid;
      vm_r <= vd_r;
      vp_r <= vm_r;
      vx_r <= vp_r;
    end
    cd_r  <= lg_c;
    d_r   <= $signed({1'b0, l1}) - $signed({1'b0, l2}) - $signed({1'b0, cfg_i.lnom});
    cm_r  <= cd_r;
    nm_r  <= d_r[D_W-1];
    mag_r <= d_r[D_W-1] ? MAG_W'(-d_r) : MAG_W'(d_r);
    cp_r  <= cm_r;
    np_r  <= nm_r;
    pl_r  <= mag_r[MAG_LO_W-1:0] * LN2_Q28;
    ph_r  <= mag_r[MAG_W-1:MAG_LO_W] * LN2_Q28;
    cx_r  <= cp_r;
    nx_r  <= np_r;
    x_r   <= xsum[X_SUM_W-1:X_SUM_W-T1_W];
  end

  // Dividing by beta*2^18 is a shift by 18 followed by a divide by beta.
  logic            d1_valid;
  logic [1:0]      d1_side;
  logic [T1_W-1:0] d1_quot;

  tat_div_pipe #(.NUM_W(T1_W), .DEN_W(BETA_W), .SIDE_W(2)) u_div_t1 (
    .clk(clk), .rst_n(rst_n), .valid_i(vx_r), .num_i(x_r), .den_i(cfg_i.beta),
    .side_i({nx_r, cx_r}), .valid_o(d1_valid), .quot_o(d1_quot), .side_o(d1_side)
  );

  // Sum of both terms of the inverse temperature.
  logic                vi_r, ci_r, vn_r, cn_r, zn_r, ngn_r;
  logic [INV_W-1:0]    t1_ext, t1_sgn;
  logic signed [INV_W-1:0] inv_r;
  logic [INV_W-1:0]    num_r;
  logic [INV_W-2:0]    den_r;

  assign t1_ext = {{(INV_W-T1_W){1'b0}}, d1_quot};
  assign t1_sgn = d1_side[1] ? -t1_ext : t1_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vi_r <= 1'b0;
      vn_r <= 1'b0;
    end else begin
      vi_r <= d1_valid;
      vn_r <= vi_r;
    end
    ci_r  <= d1_side[0];
    inv_r <= $signed(t1_sgn + {{(INV_W-TERM0_W){1'b0}}, cfg_i.term0});
    cn_r  <= ci_r;
    zn_r  <= (inv_r == '0);
    ngn_r <= inv_r[INV_W-1];
    num_r <= HUNDRED_Q40 + {2'b0, inv_r[INV_W-2:1]};
    den_r <= inv_r[INV_W-2:0];
  end

  logic             d2_valid;
  logic [2:0]       d2_side;
  logic [INV_W-1:0] d2_quot;

  tat_div_pipe #(.NUM_W(INV_W), .DEN_W(INV_W-1), .SIDE_W(3)) u_div_t (
    .clk(clk), .rst_n(rst_n), .valid_i(vn_r), .num_i(num_r), .den_i(den_r),
    .side_i({zn_r, ngn_r, cn_r}), .valid_o(d2_valid), .quot_o(d2_quot),
    .side_o(d2_side)
  );

  // Kelvin offset and output limits; a zero inverse means infinitely hot.
  logic [TEMP_W-1:0] temp_nxt;
  logic              sat_nxt;

  always_comb begin
    sat_nxt  = 1'b1;
    temp_nxt = TEMP_MAX;
    if (d2_side[2]) begin
      temp_nxt = TEMP_MAX;
    end else if (d2_side[1]) begin
      temp_nxt = TEMP_MIN;
    end else if (d2_quot > Q_HI) begin
      temp_nxt = TEMP_MAX;
    end else if (d2_quot < Q_LO) begin
      temp_nxt = TEMP_MIN;
    end else begin
      sat_nxt  = 1'b0;
      temp_nxt = d2_quot[TEMP_W-1:0] - KELVIN_CENTI;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) strobe_o <= 1'b0;
    else        strobe_o <= d2_valid;
    temp_o    <= temp_nxt;
    sat_o     <= sat_nxt;
    clamped_o <= d2_side[0];
  end

endmodule

// ===== rtl/core/thermistor_adc_to_temperature.sv =====
// Top level of the thermistor ADC reading to temperature converter.
// Depends on tat_pkg, tat_cfg, tat_front and tat_back.
//
// Use of the block:
//   A reading is taken at a rising edge where start is high and busy is low.
//   Its result shows on the out_ ports for exactly one cycle, marked by
//   out_strobe. One item can be taken every cycle while no configuration
//   rebuild holds items off; results leave in the order the items came in.
//   Each item passes through the two log2 pipelines (one squaring per
//   stage) and the two restoring dividers (one quotient bit per stage).
//   The receiver cannot stall, so nothing in the pipeline ever waits.
//   Configuration writes go over the cfg_ channel; the user must keep them
//   to times when no item is in flight, as the block does not enforce it.
//   After every accepted write, and after reset, the block derives log2 of
//   the nominal resistance and the inverse nominal temperature; busy stays
//   high and cfg_ready low until both are ready. Reset is synchronous and
//   active low; it loads the 10k / 3950 defaults and drops every item in flight.
module thermistor_adc_to_temperature #(
  parameter int ADC_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [ADC_BITS-1:0]            in_raw_sample,
  output logic                           out_strobe,
  output logic [tat_pkg::TEMP_W-1:0]     out_temperature_centi_c,
  output logic                           out_input_clamped,
  output logic                           out_result_saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tat_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tat_pkg::*;

  tat_cfg_t            cfg;
  logic                cfg_busy;
  logic                q_full;
  logic                accept;
  logic                q_valid;
  logic [ADC_BITS-1:0] q_raw;
  logic                q_clamped;

  // Items are held off while derived constants are being rebuilt.
  assign busy   = cfg_busy || q_full;
  assign accept = start && !busy;

  tat_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .busy_o(cfg_busy), .cfg_o(cfg)
  );

  // The front clamps the reading and queues it for the arithmetic.
  tat_front #(.ADC_BITS(ADC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .accept_i(accept), .raw_i(in_raw_sample),
    .full_o(q_full), .valid_o(q_valid), .raw_o(q_raw), .clamped_o(q_clamped)
  );

  // The back end is a fixed-latency pipeline that takes one item per cycle.
  tat_back #(.ADC_BITS(ADC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .valid_i(q_valid), .raw_i(q_raw),
    .clamped_i(q_clamped), .cfg_i(cfg), .strobe_o(out_strobe),
    .temp_o(out_temperature_centi_c), .clamped_o(out_input_clamped),
    .sat_o(out_result_saturated)
  );

  // A configuration write always starts a rebuild that holds items off.
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> busy && !cfg_ready)
    else $error("busy not raised after configuration write");

  // A saturated result sits on one of the two limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result_saturated |->
      (out_temperature_centi_c == TEMP_MAX || out_temperature_centi_c == TEMP_MIN))
    else $error("saturated result off the limits");

  // An unsaturated result lies inside the output range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_result_saturated |->
      ($signed(out_temperature_centi_c) <= $signed(TEMP_MAX) &&
       $signed(out_temperature_centi_c) >= $signed(TEMP_MIN)))
    else $error("result outside range without saturation flag");

endmodule

// ===== test/tb_thermistor_adc_to_temperature.sv =====
// Testbench for the thermistor ADC reading to temperature converter.
// Depends on tat_pkg and thermistor_adc_to_temperature; checks every result
// against a fixed-point beta-equation predictor kept inside this file.
`timescale 1ns / 100ps

module tb_thermistor_adc_to_temperature;
  import tat_pkg::*;

  localparam int ADC_BITS = 10;
  localparam int FULL_SCALE = (1 << ADC_BITS) - 1;
  localparam int LATENCY = 136;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 550;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ADC_BITS-1:0] in_raw_sample = '0;
  logic out_strobe;
  logic [TEMP_W-1:0] out_temperature_centi_c;
  logic out_input_clamped;
  logic out_result_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // One expected reading result.
  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic              clamped;
    logic              saturated;
  } temp_result_t;

  // A directed row: the reading and, where it is obvious, the typed-in result.
  typedef struct {
    int unsigned  raw;
    bit           typed;
    temp_result_t want;
  } reading_row_t;

  temp_result_t pending_temps[$];
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;
  bit           timed_out = 1'b0;

  // The predictor's own copy of the four registers.
  logic [SER_W-1:0]   series_ohm;
  logic [SER_W-1:0]   nominal_ohm;
  logic [BETA_W-1:0]  beta_k;
  logic [NTEMP_W-1:0] nominal_centi;

  thermistor_adc_to_temperature #(.ADC_BITS(ADC_BITS)) u_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_raw_sample           (in_raw_sample),
    .out_strobe              (out_strobe),
    .out_temperature_centi_c (out_temperature_centi_c),
    .out_input_clamped       (out_input_clamped),
    .out_result_saturated    (out_result_saturated),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  always #5 clk = ~clk;

  // Base-2 logarithm in Q30 by repeated squaring of the normalized mantissa.
  function automatic longint log2_fixed(longint unsigned x);
    int unsigned     top;
    longint unsigned mant;
    longint unsigned frac;
    if (x == 0) x = 1;
    top = 0;
    while (top < 63 && (x >> (top + 1)) != 0) top++;
    mant = (top <= 30) ? (x << (30 - top)) : (x >> (top - 30));
    frac = 0;
    for (int i = 0; i < 30; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd2 << 30)) begin
        frac = frac | 1;
        mant = mant >> 1;
      end
    end
    return longint'((longint'(top) << 30) | frac);
  endfunction

  // Beta-equation temperature of one reading under the current registers.
  function automatic temp_result_t thermistor_temp(int unsigned raw_in);
    temp_result_t    r;
    longint unsigned raw, ser, nom, beta, mag, quo, t0k, u;
    longint          diff, term1, term0, inv, t;
    raw = raw_in & FULL_SCALE;
    ser = (series_ohm == 0) ? 1 : series_ohm;
    nom = (nominal_ohm == 0) ? 1 : nominal_ohm;
    beta = (beta_k == 0) ? 1 : beta_k;
    r = '0;
    if (raw < 1) begin
      raw = 1;
      r.clamped = 1'b1;
    end
    if (raw > FULL_SCALE - 1) begin
      raw = FULL_SCALE - 1;
      r.clamped = 1'b1;
    end
    diff = log2_fixed(ser * raw) - log2_fixed(FULL_SCALE - raw) - log2_fixed(nom);
    mag = (diff < 0) ? longint'(-diff) : diff;
    mag = mag * 64'd186065279;
    quo = (mag + (beta << 17)) / (beta << 18);
    term1 = (diff < 0) ? -longint'(quo) : longint'(quo);
    t0k = longint'(signed'(nominal_centi)) + 27315;
    term0 = ((64'd100 << 40) + t0k / 2) / t0k;
    inv = term1 + term0;
    if (inv == 0) begin
      t = 50000;
      r.saturated = 1'b1;
    end else if (inv < 0) begin
      t = -10000;
      r.saturated = 1'b1;
    end else begin
      u = inv;
      t = longint'(((64'd100 << 40) + u / 2) / u) - 27315;
      if (t > 50000) begin
        t = 50000;
        r.saturated = 1'b1;
      end
      if (t < -10000) begin
        t = -10000;
        r.saturated = 1'b1;
      end
    end
    r.temp = t[TEMP_W-1:0];
    return r;
  endfunction

  // Results are taken at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_temps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: temp=%0d clamped=%0b sat=%0b",
                   $signed(out_temperature_centi_c), out_input_clamped,
                   out_result_saturated);
      end else begin
        temp_result_t w;
        w = pending_temps.pop_front();
        if (w.temp !== out_temperature_centi_c || w.clamped !== out_input_clamped ||
            w.saturated !== out_result_saturated) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected temp=%0d clamped=%0b sat=%0b, got %0d %0b %0b",
                     $signed(w.temp), w.clamped, w.saturated,
                     $signed(out_temperature_centi_c), out_input_clamped,
                     out_result_saturated);
        end
      end
    end
  end

  // The watchdog counts cycles in which nothing at all is accepted or put out.
  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || out_strobe)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1'b1;
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, often none at all.
  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic idle_for(int unsigned n);
    repeat (n) @(posedge clk);
  endtask

  // Present one reading and hold it until the block takes it. Start stays
  // high afterwards so that the next reading can follow with no gap; the
  // caller drops it before any pause.
  task automatic send_reading(int unsigned raw, bit typed, temp_result_t want);
    temp_result_t predicted;
    predicted = thermistor_temp(raw);
    if (typed && predicted !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("Table row disagrees for raw=%0d: table %0d, predicted %0d",
                 raw, $signed(want.temp), $signed(predicted.temp));
    end
    start <= 1'b1;
    in_raw_sample <= raw[ADC_BITS-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_temps.push_back(typed ? want : predicted);
  endtask

  // Let every in-flight reading drain before touching registers.
  task automatic drain();
    start <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk);
    idle_for(4);
  endtask

  // The valid line stays high after the write so that writes can follow
  // each other; set_registers drops it after the last one.
  task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SERIES:  series_ohm = value[SER_W-1:0];
      REG_NOMINAL: nominal_ohm = value[SER_W-1:0];
      REG_BETA:    beta_k = value[BETA_W-1:0];
      default:     nominal_centi = value[NTEMP_W-1:0];
    endcase
  endtask

  task automatic set_registers(int unsigned ser, int unsigned nom, int unsigned beta,
                               int ntemp);
    write_register(REG_SERIES, CFG_DATA_W'(ser));
    write_register(REG_NOMINAL, CFG_DATA_W'(nom));
    write_register(REG_BETA, CFG_DATA_W'(beta));
    write_register(REG_NTEMP, CFG_DATA_W'(ntemp));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_readings(int unsigned count);
    int unsigned raw;
    int unsigned gap;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0: raw = $urandom_range(1, 0);
        1: raw = $urandom_range(FULL_SCALE, FULL_SCALE - 1);
        default: raw = $urandom_range(FULL_SCALE);
      endcase
      send_reading(raw, 1'b0, '0);
      gap = gap_length();
      if (gap != 0) start <= 1'b0;
      idle_for(gap);
    end
  endtask

  // Directed readings under the reset defaults. No row here is typed in:
  // with series equal to nominal the reading that splits the divider
  // evenly cannot be hit exactly, so every row, the clamps among them,
  // goes through the predictor.
  reading_row_t directed_rows[$];

  initial begin
    temp_result_t none;
    none = '0;
    series_ohm = 20'd10000;
    nominal_ohm = 20'd10000;
    beta_k = 14'd3950;
    nominal_centi = 15'd2500;

    directed_rows = '{
      '{0, 1'b0, none}, '{1, 1'b0, none}, '{2, 1'b0, none},
      '{511, 1'b0, none}, '{512, 1'b0, none}, '{1022, 1'b0, none},
      '{1023, 1'b0, none}, '{341, 1'b0, none}, '{682, 1'b0, none},
      '{100, 1'b0, none}, '{900, 1'b0, none}, '{0, 1'b0, none},
      '{1023, 1'b0, none}, '{256, 1'b0, none}, '{768, 1'b0, none},
      '{85, 1'b0, none}, '{938, 1'b0, none}, '{170, 1'b0, none}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass under the reset values, back to back.
    foreach (directed_rows[i])
      send_reading(directed_rows[i].raw, directed_rows[i].typed, directed_rows[i].want);

    // The sender holds off here until every expected result is in.
    drain();

    // Extremes of every register; a zero beta with a negative nominal
    // temperature and zero resistances drives the inverse negative or to
    // saturation, and zero resistances are treated as one ohm.
    set_registers(0, 0, 0, 15'h7FFF & -5000);
    send_reading(0, 1'b1, '{temp: TEMP_MIN, clamped: 1'b1, saturated: 1'b1});
    send_reading(1023, 1'b0, none);
    random_readings(20);
    drain();

    // A huge resistance ratio over a tiny beta gives a very large inverse,
    // so the clamped full-scale reading comes out far below the range.
    set_registers(1000000, 1, 1, 15000);
    send_reading(1023, 1'b1, '{temp: TEMP_MIN, clamped: 1'b1, saturated: 1'b1});
    random_readings(20);
    drain();

    set_registers(20'hFFFFF, 20'hFFFFF, 14'h3FFF, 15'h3FFF);
    random_readings(30);
    drain();

    set_registers(1, 1000000, 10000, 15'h4000);
    random_readings(30);
    drain();

    // Several random settings; the bulk of the readings.
    for (int unsigned phase = 0; phase < 6; phase++) begin
      set_registers($urandom_range(1000000, 1), $urandom_range(1000000, 1),
                    $urandom_range(10000, 1), $urandom_range(20000) - 5000);
      random_readings(RANDOM_ITEMS / 9);
      drain();
    end

    // Back to the typical 10k / 3950 part for the last stretch.
    set_registers(10000, 10000, 3950, 2500);
    random_readings(RANDOM_ITEMS / 9);

    start <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk);
    idle_for(LATENCY + 20);

    if (mismatch_count == 0 && pending_temps.size() == 0 && !timed_out)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tat_pkg.sv
rtl/core/tat_lg2_pipe.sv
rtl/core/tat_div_pipe.sv
rtl/core/tat_cfg.sv
rtl/core/tat_front.sv
rtl/core/tat_back.sv
rtl/core/thermistor_adc_to_temperature.sv
test/tb_thermistor_adc_to_temperature.sv
